>>> hdl/cie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cie_pkg;

  localparam int DATA_BYTES    = 65536;
  localparam int SPECIAL_COUNT = 256;
  localparam int GPR_COUNT     = 16;
  localparam int MEM_AW        = $clog2(DATA_BYTES);
  localparam int SR_AW         = $clog2(SPECIAL_COUNT);
  localparam int GPR_AW        = $clog2(GPR_COUNT);

  localparam logic [1:0] EXC_NONE    = 2'd0;
  localparam logic [1:0] EXC_ILLEGAL = 2'd1;
  localparam logic [1:0] EXC_BREAK   = 2'd2;
  localparam logic [1:0] EXC_EXIT    = 2'd3;

  localparam int FLG_EQ  = 0;
  localparam int FLG_GT  = 1;
  localparam int FLG_LT  = 2;
  localparam int FLG_GTU = 3;
  localparam int FLG_LTU = 4;

  localparam logic [GPR_AW-1:0] REG_FP = GPR_AW'(0);
  localparam logic [GPR_AW-1:0] REG_SP = GPR_AW'(1);

  localparam logic [SR_AW-1:0] SR_HANDLER = SR_AW'(1);
  localparam logic [SR_AW-1:0] SR_CAUSE   = SR_AW'(2);
  localparam logic [SR_AW-1:0] SR_ARG     = SR_AW'(3);
  localparam logic [31:0]      SWI_CAUSE  = 32'd3;
  localparam logic [31:0]      SWI_EXIT   = 32'h0000_0001;
  localparam logic [31:0]      SWI_CALL   = 32'hffff_ffff;

  localparam logic [1:0] F2_INC = 2'd0;
  localparam logic [1:0] F2_DEC = 2'd1;
  localparam logic [1:0] F2_GSR = 2'd2;
  localparam logic [1:0] F2_SSR = 2'd3;

  localparam logic [3:0] BR_EQ  = 4'd0;
  localparam logic [3:0] BR_NE  = 4'd1;
  localparam logic [3:0] BR_LT  = 4'd2;
  localparam logic [3:0] BR_GT  = 4'd3;
  localparam logic [3:0] BR_LTU = 4'd4;
  localparam logic [3:0] BR_GTU = 4'd5;
  localparam logic [3:0] BR_GE  = 4'd6;
  localparam logic [3:0] BR_LE  = 4'd7;
  localparam logic [3:0] BR_GEU = 4'd8;
  localparam logic [3:0] BR_LEU = 4'd9;

  localparam logic [7:0] OP_LDI_L = 8'h01;
  localparam logic [7:0] OP_MOV   = 8'h02;
  localparam logic [7:0] OP_JSRA  = 8'h03;
  localparam logic [7:0] OP_RET   = 8'h04;
  localparam logic [7:0] OP_ADD   = 8'h05;
  localparam logic [7:0] OP_PUSH  = 8'h06;
  localparam logic [7:0] OP_POP   = 8'h07;
  localparam logic [7:0] OP_LDA_L = 8'h08;
  localparam logic [7:0] OP_STA_L = 8'h09;
  localparam logic [7:0] OP_LD_L  = 8'h0a;
  localparam logic [7:0] OP_ST_L  = 8'h0b;
  localparam logic [7:0] OP_LDO_L = 8'h0c;
  localparam logic [7:0] OP_STO_L = 8'h0d;
  localparam logic [7:0] OP_CMP   = 8'h0e;
  localparam logic [7:0] OP_NOP   = 8'h0f;
  localparam logic [7:0] OP_SEXB  = 8'h10;
  localparam logic [7:0] OP_SEXS  = 8'h11;
  localparam logic [7:0] OP_JSR   = 8'h19;
  localparam logic [7:0] OP_JMPA  = 8'h1a;
  localparam logic [7:0] OP_LDI_B = 8'h1b;
  localparam logic [7:0] OP_LD_B  = 8'h1c;
  localparam logic [7:0] OP_LDA_B = 8'h1d;
  localparam logic [7:0] OP_ST_B  = 8'h1e;
  localparam logic [7:0] OP_STA_B = 8'h1f;
  localparam logic [7:0] OP_LDI_S = 8'h20;
  localparam logic [7:0] OP_LD_S  = 8'h21;
  localparam logic [7:0] OP_LDA_S = 8'h22;
  localparam logic [7:0] OP_ST_S  = 8'h23;
  localparam logic [7:0] OP_STA_S = 8'h24;
  localparam logic [7:0] OP_JMP   = 8'h25;
  localparam logic [7:0] OP_AND   = 8'h26;
  localparam logic [7:0] OP_LSHR  = 8'h27;
  localparam logic [7:0] OP_ASHL  = 8'h28;
  localparam logic [7:0] OP_SUB   = 8'h29;
  localparam logic [7:0] OP_NEG   = 8'h2a;
  localparam logic [7:0] OP_OR    = 8'h2b;
  localparam logic [7:0] OP_NOT   = 8'h2c;
  localparam logic [7:0] OP_ASHR  = 8'h2d;
  localparam logic [7:0] OP_XOR   = 8'h2e;
  localparam logic [7:0] OP_MUL   = 8'h2f;
  localparam logic [7:0] OP_SWI   = 8'h30;
  localparam logic [7:0] OP_DIV   = 8'h31;
  localparam logic [7:0] OP_UDIV  = 8'h32;
  localparam logic [7:0] OP_MOD   = 8'h33;
  localparam logic [7:0] OP_UMOD  = 8'h34;
  localparam logic [7:0] OP_BRK   = 8'h35;
  localparam logic [7:0] OP_LDO_B = 8'h36;
  localparam logic [7:0] OP_STO_B = 8'h37;
  localparam logic [7:0] OP_LDO_S = 8'h38;
  localparam logic [7:0] OP_STO_S = 8'h39;

  typedef enum logic [4:0] {
    C_ILLEGAL, C_NOP, C_BRK, C_BRANCH, C_INCDEC, C_GSR, C_SSR, C_LDI, C_ALU,
    C_CMP, C_DIV, C_LOAD, C_STORE, C_PUSH, C_POP, C_CALL, C_RET, C_JUMP, C_SWI
  } cls_t;

  typedef enum logic [1:0] {AM_EXT, AM_REG, AM_OFF} amode_t;

  typedef struct packed {
    cls_t              cls;
    logic [GPR_AW-1:0] ra;
    logic [GPR_AW-1:0] rb;
    amode_t            amode;
    logic [2:0]        nbytes;
    logic              sdat_a;
    logic              tgt_ext;
    logic              long_f;
    logic [15:0]       iw;
    logic [31:0]       ext;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  exc;
  } res_t;

  typedef struct packed {
    logic        start;
    logic        sgn;
    logic        rem;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

  typedef enum logic [4:0] {
    XS_IDLE, XS_RDA, XS_RDB, XS_RDX, XS_FP1, XS_FP2, XS_EXEC, XS_DIV, XS_SRC,
    XS_SW3, XS_MRD, XS_MRC, XS_MWR, XS_POST, XS_WB1, XS_WB2, XS_DONE
  } xs_t;

endpackage
`default_nettype wire

>>> hdl/cie_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/cie_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cie_front
  import cie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [15:0] in_instruction,
  input  wire logic [31:0] in_extension_word,
  output logic             q_empty,
  output dec_t             q_item,
  input  wire logic        q_pop
);

  function automatic dec_t decode(input logic [15:0] iw, input logic [31:0] ext);
    dec_t d;
    d         = '0;
    d.cls     = C_ILLEGAL;
    d.ra      = iw[7:4];
    d.rb      = iw[3:0];
    d.amode   = AM_EXT;
    d.nbytes  = 3'd4;
    d.iw      = iw;
    d.ext     = ext;
    if (iw[15]) begin
      if (iw[14]) begin
        d.cls = C_BRANCH;
      end else begin
        d.ra = iw[11:8];
        case (iw[13:12])
          F2_INC, F2_DEC: d.cls = C_INCDEC;
          F2_GSR:         d.cls = C_GSR;
          default:        d.cls = C_SSR;
        endcase
      end
    end else begin
      case (iw[15:8])
        OP_LDI_L, OP_LDI_B, OP_LDI_S: begin
          d.cls = C_LDI; d.long_f = 1'b1;
        end
        OP_MOV, OP_ADD, OP_SEXB, OP_SEXS, OP_AND, OP_LSHR, OP_ASHL, OP_SUB,
        OP_NEG, OP_OR, OP_NOT, OP_ASHR, OP_XOR, OP_MUL: d.cls = C_ALU;
        OP_JSRA: begin
          d.cls = C_CALL; d.tgt_ext = 1'b1; d.long_f = 1'b1;
        end
        OP_JSR:  d.cls = C_CALL;
        OP_RET:  d.cls = C_RET;
        OP_PUSH: d.cls = C_PUSH;
        OP_POP:  d.cls = C_POP;
        OP_CMP:  d.cls = C_CMP;
        OP_NOP:  d.cls = C_NOP;
        OP_BRK:  d.cls = C_BRK;
        OP_JMPA: begin
          d.cls = C_JUMP; d.tgt_ext = 1'b1; d.long_f = 1'b1;
        end
        OP_JMP: d.cls = C_JUMP;
        OP_SWI: begin
          d.cls = C_SWI; d.long_f = 1'b1;
        end
        OP_DIV, OP_UDIV, OP_MOD, OP_UMOD: d.cls = C_DIV;
        OP_LDA_L: begin d.cls = C_LOAD; d.long_f = 1'b1; end
        OP_LD_L:  begin d.cls = C_LOAD; d.amode = AM_REG; end
        OP_LDO_L: begin d.cls = C_LOAD; d.amode = AM_OFF; d.long_f = 1'b1; end
        OP_LDA_S: begin d.cls = C_LOAD; d.nbytes = 3'd2; d.long_f = 1'b1; end
        OP_LD_S:  begin d.cls = C_LOAD; d.nbytes = 3'd2; d.amode = AM_REG; end
        OP_LDO_S: begin
          d.cls = C_LOAD; d.nbytes = 3'd2; d.amode = AM_OFF; d.long_f = 1'b1;
        end
        OP_LDA_B: begin d.cls = C_LOAD; d.nbytes = 3'd1; d.long_f = 1'b1; end
        OP_LD_B:  begin d.cls = C_LOAD; d.nbytes = 3'd1; d.amode = AM_REG; end
        OP_LDO_B: begin
          d.cls = C_LOAD; d.nbytes = 3'd1; d.amode = AM_OFF; d.long_f = 1'b1;
        end
        OP_STA_L: begin d.cls = C_STORE; d.sdat_a = 1'b1; d.long_f = 1'b1; end
        OP_ST_L:  begin d.cls = C_STORE; d.amode = AM_REG; end
        OP_STO_L: begin d.cls = C_STORE; d.amode = AM_OFF; d.long_f = 1'b1; end
        OP_STA_S: begin
          d.cls = C_STORE; d.nbytes = 3'd2; d.sdat_a = 1'b1; d.long_f = 1'b1;
        end
        OP_ST_S:  begin d.cls = C_STORE; d.nbytes = 3'd2; d.amode = AM_REG; end
        OP_STO_S: begin
          d.cls = C_STORE; d.nbytes = 3'd2; d.amode = AM_OFF; d.long_f = 1'b1;
        end
        OP_STA_B: begin
          d.cls = C_STORE; d.nbytes = 3'd1; d.sdat_a = 1'b1; d.long_f = 1'b1;
        end
        OP_ST_B:  begin d.cls = C_STORE; d.nbytes = 3'd1; d.amode = AM_REG; end
        OP_STO_B: begin
          d.cls = C_STORE; d.nbytes = 3'd1; d.amode = AM_OFF; d.long_f = 1'b1;
        end
        default: d.cls = C_ILLEGAL;
      endcase
    end
    return d;
  endfunction

  dec_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push_ok, pop_ok;

  assign in_full = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_item  = slot_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wp_r] <= decode(in_instruction, in_extension_word);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= !wp_r;
      if (pop_ok)  rp_r <= !rp_r;
      if (push_ok && !pop_ok) cnt_r <= cnt_r + 2'd1;
      else if (pop_ok && !push_ok) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/cie_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cie_div
  import cie_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy_r, fin_r;
  logic [5:0]  cnt_r;
  logic [31:0] q_r, r_r, d_r;
  logic        negq_r, negr_r, rem_r, zero_r;
  logic [32:0] rr, diff;

  assign rr   = {r_r, q_r[31]};
  assign diff = rr - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      fin_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring on magnitudes
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r    <= (req.sgn && req.a[31]) ? (32'd0 - req.a) : req.a;
      d_r    <= (req.sgn && req.b[31]) ? (32'd0 - req.b) : req.b;
      r_r    <= 32'd0;
      negq_r <= req.sgn && (req.a[31] != req.b[31]);
      negr_r <= req.sgn && req.a[31];
      rem_r  <= req.rem;
      zero_r <= (req.b == 32'd0);
    end else if (busy_r) begin
      if (!diff[32]) begin
        r_r <= diff[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= rr[31:0];
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp.done = fin_r;
    if (zero_r)     rsp.result = 32'd0;
    else if (rem_r) rsp.result = negr_r ? (32'd0 - r_r) : r_r;
    else            rsp.result = negq_r ? (32'd0 - q_r) : q_r;
  end

endmodule
`default_nettype wire

>>> hdl/cie_exec.sv
`timescale 1ns / 1ps
`default_nettype none
module cie_exec
  import cie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire dec_t        q_item,
  output logic             q_pop,
  input  wire logic        res_full,
  output logic             res_push,
  output res_t             res,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  xs_t               state_r, state_nxt;
  dec_t              item_r, item_nxt;
  logic [31:0]       pc_r, pc_nxt, npc_r, npc_nxt;
  logic [4:0]        flags_r, flags_nxt;
  logic [1:0]        exc_r, exc_nxt;
  logic [31:0]       av_r, av_nxt, bv_r, bv_nxt, fp_r, fp_nxt, sp_r, sp_nxt;
  logic [31:0]       tmp_r, tmp_nxt, mdata_r, mdata_nxt;
  logic [MEM_AW-1:0] maddr_r, maddr_nxt;
  logic [2:0]        mcnt_r, mcnt_nxt;
  logic              phase_r, phase_nxt;
  logic              wb1_en_r, wb1_en_nxt, wb2_en_r, wb2_en_nxt;
  logic [GPR_AW-1:0] wb1_idx_r, wb1_idx_nxt, wb2_idx_r, wb2_idx_nxt;
  logic [31:0]       wb1_val_r, wb1_val_nxt, wb2_val_r, wb2_val_nxt;
  logic [GPR_AW-1:0] rd_idx_r, rd_idx_nxt;
  logic              sr_hit_r, sr_hit_nxt;
  logic              gvalid_r [GPR_COUNT];
  logic              svalid_r [SPECIAL_COUNT];

  logic              g_we;
  logic [GPR_AW-1:0] g_waddr, g_raddr;
  logic [31:0]       g_wdata, g_rdata;
  logic              s_we;
  logic [SR_AW-1:0]  s_waddr, s_raddr;
  logic [31:0]       s_wdata, s_rdata;
  logic              m_we;
  logic [MEM_AW-1:0] m_waddr, m_raddr;
  logic [7:0]        m_wdata, m_rdata;
  div_req_t          dreq;
  div_rsp_t          drsp;

  logic [31:0] gcap, alu_out, br_off, mem_ea, st_data;
  logic [7:0]  imm;
  logic [SR_AW-1:0] sr_idx;
  logic        sr_ok, take;
  logic [4:0]  cmp_f;

  cie_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_gpr (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  cie_ram #(.WIDTH(32), .DEPTH(SPECIAL_COUNT)) u_sreg (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  cie_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dmem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  cie_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign gcap   = gvalid_r[rd_idx_r] ? g_rdata : 32'd0;
  assign imm    = item_r.iw[7:0];
  assign sr_idx = imm[SR_AW-1:0];
  assign sr_ok  = ({24'd0, imm} < 32'(SPECIAL_COUNT));
  assign br_off = {{21{item_r.iw[9]}}, item_r.iw[9:0], 1'b0};

  always_comb begin
    case (item_r.iw[15:8])
      OP_MOV:  alu_out = bv_r;
      OP_ADD:  alu_out = av_r + bv_r;
      OP_SEXB: alu_out = {{24{bv_r[7]}}, bv_r[7:0]};
      OP_SEXS: alu_out = {{16{bv_r[15]}}, bv_r[15:0]};
      OP_AND:  alu_out = av_r & bv_r;
      OP_LSHR: alu_out = (|bv_r[31:5]) ? 32'd0 : (av_r >> bv_r[4:0]);
      OP_ASHL: alu_out = (|bv_r[31:5]) ? 32'd0 : (av_r << bv_r[4:0]);
      OP_SUB:  alu_out = av_r - bv_r;
      OP_NEG:  alu_out = 32'd0 - bv_r;
      OP_OR:   alu_out = av_r | bv_r;
      OP_NOT:  alu_out = ~bv_r;
      OP_ASHR: alu_out = (|bv_r[31:5]) ? {32{av_r[31]}}
                                       : 32'($signed(av_r) >>> bv_r[4:0]);
      OP_XOR:  alu_out = av_r ^ bv_r;
      OP_MUL:  alu_out = av_r * bv_r;
      default: alu_out = 32'd0;
    endcase
  end

  always_comb begin
    cmp_f = 5'd0;
    if (av_r == bv_r) begin
      cmp_f[FLG_EQ] = 1'b1;
    end else begin
      cmp_f[FLG_LT]  = ($signed(av_r) < $signed(bv_r));
      cmp_f[FLG_GT]  = !($signed(av_r) < $signed(bv_r));
      cmp_f[FLG_LTU] = (av_r < bv_r);
      cmp_f[FLG_GTU] = !(av_r < bv_r);
    end
  end

  always_comb begin
    case (item_r.iw[13:10])
      BR_EQ:   take = flags_r[FLG_EQ];
      BR_NE:   take = !flags_r[FLG_EQ];
      BR_LT:   take = flags_r[FLG_LT];
      BR_GT:   take = flags_r[FLG_GT];
      BR_LTU:  take = flags_r[FLG_LTU];
      BR_GTU:  take = flags_r[FLG_GTU];
      BR_GE:   take = flags_r[FLG_GT] || flags_r[FLG_EQ];
      BR_LE:   take = flags_r[FLG_LT] || flags_r[FLG_EQ];
      BR_GEU:  take = flags_r[FLG_GTU] || flags_r[FLG_EQ];
      BR_LEU:  take = flags_r[FLG_LTU] || flags_r[FLG_EQ];
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    case (item_r.amode)
      AM_EXT:  mem_ea = item_r.ext;
      AM_REG:  mem_ea = (item_r.cls == C_STORE) ? av_r : bv_r;
      default: mem_ea = item_r.ext + ((item_r.cls == C_STORE) ? av_r : bv_r);
    endcase
    case (item_r.nbytes)
      3'd1:    st_data = {(item_r.sdat_a ? av_r[7:0] : bv_r[7:0]), 24'd0};
      3'd2:    st_data = {(item_r.sdat_a ? av_r[15:0] : bv_r[15:0]), 16'd0};
      default: st_data = item_r.sdat_a ? av_r : bv_r;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    pc_nxt      = pc_r;
    npc_nxt     = npc_r;
    flags_nxt   = flags_r;
    exc_nxt     = exc_r;
    av_nxt      = av_r;
    bv_nxt      = bv_r;
    fp_nxt      = fp_r;
    sp_nxt      = sp_r;
    tmp_nxt     = tmp_r;
    mdata_nxt   = mdata_r;
    maddr_nxt   = maddr_r;
    mcnt_nxt    = mcnt_r;
    phase_nxt   = phase_r;
    wb1_en_nxt  = wb1_en_r;
    wb1_idx_nxt = wb1_idx_r;
    wb1_val_nxt = wb1_val_r;
    wb2_en_nxt  = wb2_en_r;
    wb2_idx_nxt = wb2_idx_r;
    wb2_val_nxt = wb2_val_r;
    rd_idx_nxt  = rd_idx_r;
    sr_hit_nxt  = sr_hit_r;
    q_pop       = 1'b0;
    res_push    = 1'b0;
    g_we        = 1'b0;
    g_waddr     = wb1_idx_r;
    g_wdata     = wb1_val_r;
    g_raddr     = item_r.ra;
    s_we        = 1'b0;
    s_waddr     = sr_idx;
    s_wdata     = av_r;
    s_raddr     = sr_idx;
    m_we        = 1'b0;
    m_waddr     = maddr_r;
    m_wdata     = mdata_r[31:24];
    m_raddr     = maddr_r;
    dreq.start  = 1'b0;
    dreq.sgn    = (item_r.iw[15:8] == OP_DIV) || (item_r.iw[15:8] == OP_MOD);
    dreq.rem    = (item_r.iw[15:8] == OP_MOD) || (item_r.iw[15:8] == OP_UMOD);
    dreq.a      = av_r;
    dreq.b      = bv_r;

    case (state_r)
      XS_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          item_nxt   = q_item;
          exc_nxt    = EXC_NONE;
          wb1_en_nxt = 1'b0;
          wb2_en_nxt = 1'b0;
          phase_nxt  = 1'b0;
          state_nxt  = XS_RDA;
        end
      end
      XS_RDA: begin
        g_raddr    = item_r.ra;
        rd_idx_nxt = item_r.ra;
        state_nxt  = XS_RDB;
      end
      XS_RDB: begin
        av_nxt     = gcap;
        g_raddr    = item_r.rb;
        rd_idx_nxt = item_r.rb;
        state_nxt  = XS_RDX;
      end
      XS_RDX: begin
        bv_nxt  = gcap;
        npc_nxt = pc_r + (item_r.long_f ? 32'd6 : 32'd2);
        if (item_r.cls == C_CALL || item_r.cls == C_RET || item_r.cls == C_SWI) begin
          g_raddr    = REG_FP;
          rd_idx_nxt = REG_FP;
          state_nxt  = XS_FP1;
        end else begin
          state_nxt = XS_EXEC;
        end
      end
      XS_FP1: begin
        fp_nxt     = gcap;
        g_raddr    = REG_SP;
        rd_idx_nxt = REG_SP;
        state_nxt  = XS_FP2;
      end
      XS_FP2: begin
        sp_nxt    = gcap;
        state_nxt = XS_EXEC;
      end
      XS_EXEC: begin
        state_nxt = XS_DONE;
        case (item_r.cls)
          C_ILLEGAL: exc_nxt = EXC_ILLEGAL;
          C_BRK: begin
            exc_nxt = EXC_BREAK;
            npc_nxt = pc_r;
          end
          C_BRANCH: begin
            if (item_r.iw[13:10] > BR_LEU) exc_nxt = EXC_ILLEGAL;
            else if (take) npc_nxt = pc_r + 32'd2 + br_off;
          end
          C_INCDEC: begin
            wb1_en_nxt  = 1'b1;
            wb1_idx_nxt = item_r.ra;
            wb1_val_nxt = (item_r.iw[13:12] == F2_DEC) ? av_r - {24'd0, imm}
                                                       : av_r + {24'd0, imm};
            state_nxt   = XS_WB1;
          end
          C_GSR: begin
            s_raddr    = sr_idx;
            sr_hit_nxt = sr_ok && svalid_r[sr_idx];
            state_nxt  = XS_SRC;
          end
          C_SSR: begin
            s_we    = sr_ok;
            s_waddr = sr_idx;
            s_wdata = av_r;
          end
          C_LDI, C_ALU: begin
            wb1_en_nxt  = 1'b1;
            wb1_idx_nxt = item_r.ra;
            wb1_val_nxt = (item_r.cls == C_LDI) ? item_r.ext : alu_out;
            state_nxt   = XS_WB1;
          end
          C_CMP: flags_nxt = cmp_f;
          C_DIV: begin
            dreq.start = 1'b1;
            state_nxt  = XS_DIV;
          end
          C_LOAD: begin
            maddr_nxt = mem_ea[MEM_AW-1:0];
            mcnt_nxt  = item_r.nbytes;
            mdata_nxt = 32'd0;
            state_nxt = XS_MRD;
          end
          C_STORE: begin
            maddr_nxt = mem_ea[MEM_AW-1:0];
            mcnt_nxt  = item_r.nbytes;
            mdata_nxt = st_data;
            state_nxt = XS_MWR;
          end
          C_PUSH: begin
            maddr_nxt   = MEM_AW'(av_r - 32'd4);
            mcnt_nxt    = 3'd4;
            mdata_nxt   = bv_r;
            wb1_en_nxt  = 1'b1;
            wb1_idx_nxt = item_r.ra;
            wb1_val_nxt = av_r - 32'd4;
            state_nxt   = XS_MWR;
          end
          C_POP: begin
            maddr_nxt = av_r[MEM_AW-1:0];
            mcnt_nxt  = 3'd4;
            mdata_nxt = 32'd0;
            state_nxt = XS_MRD;
          end
          C_CALL: begin
            // return address is the fall-through pc already in npc_r
            npc_nxt   = item_r.tgt_ext ? item_r.ext : av_r;
            maddr_nxt = MEM_AW'(sp_r - 32'd8);
            mcnt_nxt  = 3'd4;
            mdata_nxt = npc_r;
            state_nxt = XS_MWR;
          end
          C_RET: begin
            maddr_nxt = fp_r[MEM_AW-1:0];
            mcnt_nxt  = 3'd4;
            mdata_nxt = 32'd0;
            state_nxt = XS_MRD;
          end
          C_JUMP: npc_nxt = item_r.tgt_ext ? item_r.ext : av_r;
          C_SWI: begin
            s_we      = 1'b1;
            s_waddr   = SR_CAUSE;
            s_wdata   = SWI_CAUSE;
            state_nxt = XS_SW3;
          end
          default: ;
        endcase
      end
      XS_SW3: begin
        s_we      = 1'b1;
        s_waddr   = SR_ARG;
        s_wdata   = item_r.ext;
        state_nxt = XS_DONE;
        if (item_r.ext == SWI_EXIT) begin
          exc_nxt = EXC_EXIT;
        end else if (item_r.ext == SWI_CALL) begin
          s_raddr    = SR_HANDLER;
          sr_hit_nxt = svalid_r[SR_HANDLER];
          state_nxt  = XS_SRC;
        end
      end
      XS_SRC: begin
        if (item_r.cls == C_SWI) begin
          npc_nxt   = sr_hit_r ? s_rdata : 32'd0;
          maddr_nxt = MEM_AW'(sp_r - 32'd8);
          mcnt_nxt  = 3'd4;
          mdata_nxt = npc_r;
          state_nxt = XS_MWR;
        end else begin
          wb1_en_nxt  = 1'b1;
          wb1_idx_nxt = item_r.ra;
          wb1_val_nxt = sr_hit_r ? s_rdata : 32'd0;
          state_nxt   = XS_WB1;
        end
      end
      XS_DIV: begin
        if (drsp.done) begin
          wb1_en_nxt  = 1'b1;
          wb1_idx_nxt = item_r.ra;
          wb1_val_nxt = drsp.result;
          state_nxt   = XS_WB1;
        end
      end
      XS_MRD: begin
        m_raddr   = maddr_r;
        state_nxt = XS_MRC;
      end
      XS_MRC: begin
        mdata_nxt = {mdata_r[23:0], m_rdata};
        maddr_nxt = maddr_r + MEM_AW'(1);
        mcnt_nxt  = mcnt_r - 3'd1;
        state_nxt = (mcnt_r == 3'd1) ? XS_POST : XS_MRD;
      end
      XS_MWR: begin
        m_we      = 1'b1;
        m_waddr   = maddr_r;
        m_wdata   = mdata_r[31:24];
        mdata_nxt = {mdata_r[23:0], 8'd0};
        maddr_nxt = maddr_r + MEM_AW'(1);
        mcnt_nxt  = mcnt_r - 3'd1;
        if (mcnt_r == 3'd1) state_nxt = XS_POST;
      end
      XS_POST: begin
        state_nxt = XS_WB1;
        case (item_r.cls)
          C_LOAD: begin
            wb1_en_nxt  = 1'b1;
            wb1_idx_nxt = item_r.ra;
            wb1_val_nxt = mdata_r;
          end
          C_POP: begin
            // ra goes last so it wins when both fields match
            wb1_en_nxt  = 1'b1;
            wb1_idx_nxt = item_r.rb;
            wb1_val_nxt = mdata_r;
            wb2_en_nxt  = 1'b1;
            wb2_idx_nxt = item_r.ra;
            wb2_val_nxt = av_r + 32'd4;
          end
          C_RET: begin
            if (!phase_r) begin
              tmp_nxt   = mdata_r;
              maddr_nxt = MEM_AW'(fp_r + 32'd4);
              mcnt_nxt  = 3'd4;
              mdata_nxt = 32'd0;
              phase_nxt = 1'b1;
              state_nxt = XS_MRD;
            end else begin
              npc_nxt     = mdata_r;
              wb1_en_nxt  = 1'b1;
              wb1_idx_nxt = REG_FP;
              wb1_val_nxt = tmp_r;
              wb2_en_nxt  = 1'b1;
              wb2_idx_nxt = REG_SP;
              wb2_val_nxt = fp_r + 32'd12;
            end
          end
          C_CALL, C_SWI: begin
            if (!phase_r) begin
              maddr_nxt = MEM_AW'(sp_r - 32'd12);
              mcnt_nxt  = 3'd4;
              mdata_nxt = fp_r;
              phase_nxt = 1'b1;
              state_nxt = XS_MWR;
            end else begin
              wb1_en_nxt  = 1'b1;
              wb1_idx_nxt = REG_SP;
              wb1_val_nxt = sp_r - 32'd12;
              wb2_en_nxt  = 1'b1;
              wb2_idx_nxt = REG_FP;
              wb2_val_nxt = sp_r - 32'd12;
            end
          end
          C_PUSH: ;
          default: state_nxt = XS_DONE;
        endcase
      end
      XS_WB1: begin
        g_we      = wb1_en_r;
        g_waddr   = wb1_idx_r;
        g_wdata   = wb1_val_r;
        state_nxt = XS_WB2;
      end
      XS_WB2: begin
        g_we      = wb2_en_r;
        g_waddr   = wb2_idx_r;
        g_wdata   = wb2_val_r;
        state_nxt = XS_DONE;
      end
      XS_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          pc_nxt    = npc_r;
          state_nxt = XS_IDLE;
        end
      end
      default: state_nxt = XS_IDLE;
    endcase

    if (cfg_we) pc_nxt = cfg_wdata;
  end

  assign res.next_pc = npc_r;
  assign res.exc     = exc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= XS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= 32'd0;
      flags_r <= 5'd0;
      for (int i = 0; i < GPR_COUNT; i++) gvalid_r[i] <= 1'b0;
      for (int i = 0; i < SPECIAL_COUNT; i++) svalid_r[i] <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      flags_r <= flags_nxt;
      if (g_we) gvalid_r[g_waddr] <= 1'b1;
      if (s_we) svalid_r[s_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    npc_r     <= npc_nxt;
    exc_r     <= exc_nxt;
    av_r      <= av_nxt;
    bv_r      <= bv_nxt;
    fp_r      <= fp_nxt;
    sp_r      <= sp_nxt;
    tmp_r     <= tmp_nxt;
    mdata_r   <= mdata_nxt;
    maddr_r   <= maddr_nxt;
    mcnt_r    <= mcnt_nxt;
    phase_r   <= phase_nxt;
    wb1_en_r  <= wb1_en_nxt;
    wb1_idx_r <= wb1_idx_nxt;
    wb1_val_r <= wb1_val_nxt;
    wb2_en_r  <= wb2_en_nxt;
    wb2_idx_r <= wb2_idx_nxt;
    wb2_val_r <= wb2_val_nxt;
    rd_idx_r  <= rd_idx_nxt;
    sr_hit_r  <= sr_hit_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/cpu_instruction_execute_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Instruction execute unit: one 16-bit instruction plus the following 32-bit
// word per beat, one result beat (next pc, exception code) per instruction.
// A two-entry decode queue takes beats at full clock rate while it is not
// full; the back end runs one instruction at a time: it takes it from the
// queue, reads the register file, reads the frame and stack pointers on calls,
// returns and swi, executes, then reads each data byte loaded as an address
// step and a capture step, or writes each byte stored (registered-read byte
// memory), takes a post step after each memory access, writes registers back
// where a register changes, and hands off the result. Divide and modulo use a
// 32-step iterative divider.
module cpu_instruction_execute_top
  import cie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [15:0] in_instruction,
  input  wire logic [31:0] in_extension_word,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_next_pc,
  output logic [1:0]       out_exception_code,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  logic       q_empty, q_pop;
  dec_t       q_item;
  logic       res_push, res_full;
  res_t       res;
  res_t       oq_r [2];
  logic       oq_wp_r, oq_rp_r;
  logic [1:0] oq_cnt_r;
  logic       oq_pop;

  cie_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_instruction(in_instruction), .in_extension_word(in_extension_word),
    .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop)
  );

  cie_exec u_exec (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop),
    .res_full(res_full), .res_push(res_push), .res(res),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // result queue: hold finished beats while the consumer stalls
  assign res_full           = (oq_cnt_r == 2'd2);
  assign out_empty          = (oq_cnt_r == 2'd0);
  assign oq_pop             = out_pop && !out_empty;
  assign out_next_pc        = oq_r[oq_rp_r].next_pc;
  assign out_exception_code = oq_r[oq_rp_r].exc;

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[oq_wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (res_push) oq_wp_r <= !oq_wp_r;
      if (oq_pop)   oq_rp_r <= !oq_rp_r;
      if (res_push && !oq_pop) oq_cnt_r <= oq_cnt_r + 2'd1;
      else if (oq_pop && !res_push) oq_cnt_r <= oq_cnt_r - 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_cnt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_pop && !res_push) |=> (oq_cnt_r == $past(oq_cnt_r) - 2'd1))
    else $error("result queue count did not drop on pop");

  a_cnt_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !oq_pop) |=> (oq_cnt_r == $past(oq_cnt_r) + 2'd1))
    else $error("result queue count did not rise on push");
`endif

endmodule
`default_nettype wire

>>> tb/sv/cpu_instruction_execute_checker.sv
`timescale 1ns / 1ps
module cpu_instruction_execute_checker
  import cie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [15:0] in_instruction,
  input  logic [31:0] in_extension_word,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [31:0] out_next_pc,
  input  logic [1:0]  out_exception_code,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          mismatch_count,
  output int          pending
);

  logic [31:0] gpr [GPR_COUNT];
  logic [31:0] spr [SPECIAL_COUNT];
  logic [7:0]  dmem [DATA_BYTES];
  logic [4:0]  flags;
  logic [31:0] pc_q;
  res_t        expected_results [$];

  function automatic logic [31:0] rd8(logic [31:0] a);
    return {24'd0, dmem[a[MEM_AW-1:0]]};
  endfunction

  function automatic logic [31:0] rd16(logic [31:0] a);
    return (rd8(a) << 8) | rd8(a + 32'd1);
  endfunction

  function automatic logic [31:0] rd32(logic [31:0] a);
    return (rd16(a) << 16) | rd16(a + 32'd2);
  endfunction

  task automatic wr8(logic [31:0] a, logic [31:0] v);
    dmem[a[MEM_AW-1:0]] = v[7:0];
  endtask

  task automatic wr16(logic [31:0] a, logic [31:0] v);
    wr8(a, v >> 8);
    wr8(a + 32'd1, v);
  endtask

  task automatic wr32(logic [31:0] a, logic [31:0] v);
    wr16(a, v >> 16);
    wr16(a + 32'd2, v);
  endtask

  // static chain slot, return address, then saved frame pointer
  task automatic push_call_frame(logic [31:0] ret);
    logic [31:0] sp;
    sp = gpr[REG_SP] - 32'd8;
    wr32(sp, ret);
    sp = sp - 32'd4;
    wr32(sp, gpr[REG_FP]);
    gpr[REG_SP] = sp;
    gpr[REG_FP] = sp;
  endtask

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b, bit rem);
    logic [31:0] q, r;
    if (b == 0) return 32'd0;
    q = abs32(a) / abs32(b);
    r = abs32(a) % abs32(b);
    if (rem) return a[31] ? -r : r;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  task automatic execute_instruction(input logic [15:0] iw, input logic [31:0] ext,
                                     output res_t res);
    logic [31:0] pc, av, bv, off, sp, fill;
    logic [1:0]  exc;
    logic [3:0]  ra, rb, r;
    logic [7:0]  imm;
    bit          take;
    pc = pc_q;
    exc = EXC_NONE;
    ra = iw[7:4];
    rb = iw[3:0];
    av = gpr[ra];
    bv = gpr[rb];
    if (iw[15] && iw[14]) begin
      off = {{22{iw[9]}}, iw[9:0]} << 1;
      take = 0;
      case (iw[13:10])
        BR_EQ:  take = flags[FLG_EQ];
        BR_NE:  take = !flags[FLG_EQ];
        BR_LT:  take = flags[FLG_LT];
        BR_GT:  take = flags[FLG_GT];
        BR_LTU: take = flags[FLG_LTU];
        BR_GTU: take = flags[FLG_GTU];
        BR_GE:  take = flags[FLG_GT] | flags[FLG_EQ];
        BR_LE:  take = flags[FLG_LT] | flags[FLG_EQ];
        BR_GEU: take = flags[FLG_GTU] | flags[FLG_EQ];
        BR_LEU: take = flags[FLG_LTU] | flags[FLG_EQ];
        default: exc = EXC_ILLEGAL;
      endcase
      if (take) pc = pc + off;
    end else if (iw[15]) begin
      r = iw[11:8];
      imm = iw[7:0];
      case (iw[13:12])
        F2_INC: gpr[r] = gpr[r] + imm;
        F2_DEC: gpr[r] = gpr[r] - imm;
        F2_GSR: gpr[r] = (imm < SPECIAL_COUNT) ? spr[imm] : 32'd0;
        default: if (imm < SPECIAL_COUNT) spr[imm] = gpr[r];
      endcase
    end else begin
      case (iw[15:8])
        OP_LDI_L, OP_LDI_B, OP_LDI_S: begin gpr[ra] = ext; pc += 4; end
        OP_MOV:  gpr[ra] = bv;
        OP_JSRA: begin push_call_frame(pc + 32'd6); pc = ext - 32'd2; end
        OP_RET: begin
          sp = gpr[REG_FP];
          gpr[REG_FP] = rd32(sp);
          pc = rd32(sp + 32'd4) - 32'd2;
          gpr[REG_SP] = sp + 32'd12;
        end
        OP_ADD: gpr[ra] = av + bv;
        OP_PUSH: begin
          sp = av - 32'd4;
          wr32(sp, bv);
          gpr[ra] = sp;
        end
        OP_POP: begin
          gpr[rb] = rd32(av);
          gpr[ra] = av + 32'd4;
        end
        OP_LDA_L: begin gpr[ra] = rd32(ext); pc += 4; end
        OP_STA_L: begin wr32(ext, av); pc += 4; end
        OP_LD_L:  gpr[ra] = rd32(bv);
        OP_ST_L:  wr32(av, bv);
        OP_LDO_L: begin gpr[ra] = rd32(ext + bv); pc += 4; end
        OP_STO_L: begin wr32(ext + av, bv); pc += 4; end
        OP_CMP: begin
          flags = '0;
          if (av == bv) flags[FLG_EQ] = 1;
          else begin
            if ($signed(av) < $signed(bv)) flags[FLG_LT] = 1; else flags[FLG_GT] = 1;
            if (av < bv) flags[FLG_LTU] = 1; else flags[FLG_GTU] = 1;
          end
        end
        OP_NOP: ;
        OP_SEXB: gpr[ra] = {{24{bv[7]}}, bv[7:0]};
        OP_SEXS: gpr[ra] = {{16{bv[15]}}, bv[15:0]};
        OP_JSR:  begin push_call_frame(pc + 32'd2); pc = av - 32'd2; end
        OP_JMPA: pc = ext - 32'd2;
        OP_LD_B:  gpr[ra] = rd8(bv);
        OP_LDA_B: begin gpr[ra] = rd8(ext); pc += 4; end
        OP_ST_B:  wr8(av, bv);
        OP_STA_B: begin wr8(ext, av); pc += 4; end
        OP_LD_S:  gpr[ra] = rd16(bv);
        OP_LDA_S: begin gpr[ra] = rd16(ext); pc += 4; end
        OP_ST_S:  wr16(av, bv);
        OP_STA_S: begin wr16(ext, av); pc += 4; end
        OP_JMP:  pc = av - 32'd2;
        OP_AND:  gpr[ra] = av & bv;
        OP_LSHR: gpr[ra] = (bv >= 32) ? 32'd0 : av >> bv[4:0];
        OP_ASHL: gpr[ra] = (bv >= 32) ? 32'd0 : av << bv[4:0];
        OP_SUB:  gpr[ra] = av - bv;
        OP_NEG:  gpr[ra] = -bv;
        OP_OR:   gpr[ra] = av | bv;
        OP_NOT:  gpr[ra] = ~bv;
        OP_ASHR: begin
          fill = {32{av[31]}};
          gpr[ra] = (bv >= 32) ? fill : $unsigned($signed(av) >>> bv[4:0]);
        end
        OP_XOR:  gpr[ra] = av ^ bv;
        OP_MUL:  gpr[ra] = av * bv;
        OP_SWI: begin
          spr[SR_CAUSE] = SWI_CAUSE;
          spr[SR_ARG] = ext;
          if (ext == SWI_EXIT) exc = EXC_EXIT;
          else if (ext == SWI_CALL) begin
            push_call_frame(pc + 32'd6);
            pc = spr[SR_HANDLER] - 32'd6;
          end
          pc += 4;
        end
        OP_DIV:  gpr[ra] = signed_divide(av, bv, 0);
        OP_UDIV: gpr[ra] = (bv == 0) ? 32'd0 : av / bv;
        OP_MOD:  gpr[ra] = signed_divide(av, bv, 1);
        OP_UMOD: gpr[ra] = (bv == 0) ? 32'd0 : av % bv;
        OP_BRK:  begin exc = EXC_BREAK; pc -= 2; end
        OP_LDO_B: begin gpr[ra] = rd8(ext + bv); pc += 4; end
        OP_STO_B: begin wr8(ext + av, bv); pc += 4; end
        OP_LDO_S: begin gpr[ra] = rd16(ext + bv); pc += 4; end
        OP_STO_S: begin wr16(ext + av, bv); pc += 4; end
        default: exc = EXC_ILLEGAL;
      endcase
    end
    pc = pc + 32'd2;
    pc_q = pc;
    res.next_pc = pc;
    res.exc = exc;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = '0;
      foreach (spr[i]) spr[i] = '0;
      flags = '0;
      pc_q = '0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) pc_q = cfg_wdata;
      if (in_push && !in_full) begin
        execute_instruction(in_instruction, in_extension_word, want);
        expected_results.push_back(want);
      end
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with nothing expected: pc %h exc %0d",
                     $realtime, out_next_pc, out_exception_code);
        end else begin
          want = expected_results.pop_front();
          if (out_next_pc !== want.next_pc || out_exception_code !== want.exc) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected pc %h exc %0d, got pc %h exc %0d", $realtime,
                       want.next_pc, want.exc, out_next_pc, out_exception_code);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/sv/tb_cpu_instruction_execute_top.sv
`timescale 1ns / 1ps
module tb_cpu_instruction_execute_top;
  import cie_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [15:0] in_instruction;
  logic [31:0] in_extension_word;
  logic        out_empty;
  logic        out_pop;
  logic [31:0] out_next_pc;
  logic [1:0]  out_exception_code;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          mismatch_count;
  int          pending;
  int          quiet_cycles;
  bit          quiet;
  int          pop_hold;

  localparam logic [7:0] LEGAL_OPS [50] = '{
    OP_LDI_L, OP_MOV, OP_JSRA, OP_RET, OP_ADD, OP_PUSH, OP_POP, OP_LDA_L, OP_STA_L,
    OP_LD_L, OP_ST_L, OP_LDO_L, OP_STO_L, OP_CMP, OP_NOP, OP_SEXB, OP_SEXS, OP_JSR,
    OP_JMPA, OP_LDI_B, OP_LD_B, OP_LDA_B, OP_ST_B, OP_STA_B, OP_LDI_S, OP_LD_S,
    OP_LDA_S, OP_ST_S, OP_STA_S, OP_JMP, OP_AND, OP_LSHR, OP_ASHL, OP_SUB, OP_NEG,
    OP_OR, OP_NOT, OP_ASHR, OP_XOR, OP_MUL, OP_SWI, OP_DIV, OP_UDIV, OP_MOD, OP_UMOD,
    OP_BRK, OP_LDO_B, OP_STO_B, OP_LDO_S, OP_STO_S
  };

  cpu_instruction_execute_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_instruction(in_instruction), .in_extension_word(in_extension_word),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_next_pc(out_next_pc), .out_exception_code(out_exception_code),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  cpu_instruction_execute_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_instruction(in_instruction), .in_extension_word(in_extension_word),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_next_pc(out_next_pc), .out_exception_code(out_exception_code),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // result side: random stall bursts, none once the run goes quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0;
      pop_hold = 0;
    end else if (quiet) begin
      out_pop <= 1;
    end else if (pop_hold != 0) begin
      pop_hold--;
      out_pop <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      pop_hold = $urandom_range(0, 16);
      out_pop <= 0;
    end else begin
      out_pop <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we)
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [15:0] op_rr(logic [7:0] op, int ra, int rb);
    return {op, 4'(ra), 4'(rb)};
  endfunction

  function automatic bit reads_memory(logic [15:0] iw);
    if (iw[15]) return 0;
    case (iw[15:8])
      OP_RET, OP_POP, OP_LDA_L, OP_LD_L, OP_LDO_L, OP_LDA_B, OP_LD_B, OP_LDO_B,
      OP_LDA_S, OP_LD_S, OP_LDO_S: return 1;
      default: return 0;
    endcase
  endfunction

  // random addresses may hit unwritten bytes: reads only come from directed beats
  function automatic logic [15:0] random_instruction();
    int pick;
    logic [15:0] iw;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        iw = {LEGAL_OPS[$urandom_range(0, 49)], 8'($urandom)};
      else if (pick < 80)
        iw = {2'b10, 2'($urandom), 4'($urandom), 8'($urandom)};
      else if (pick < 92)
        iw = {2'b11, 4'($urandom_range(0, 9)), 10'($urandom)};
      else
        iw = 16'($urandom);
    end while (reads_memory(iw));
    return iw;
  endfunction

  function automatic logic [31:0] random_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 4) return $urandom_range(0, 40);
    if (pick == 4) return SWI_CALL;
    if (pick == 5) return SWI_EXIT;
    if (pick == 6) return 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic send_beat(logic [15:0] iw, logic [31:0] ext);
    in_push <= 1;
    in_instruction <= iw;
    in_extension_word <= ext;
    do @(posedge clk); while (in_full);
  endtask

  task automatic idle_sender(int n);
    in_push <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_random(int n);
    repeat (n) begin
      if (!quiet && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 17));
      send_beat(random_instruction(), random_word());
    end
  endtask

  initial begin
    rst_n = 0;
    in_push = 0;
    in_instruction = '0;
    in_extension_word = '0;
    cfg_we = 0;
    cfg_wdata = '0;
    quiet = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_start_pc(32'd0);

    for (int r = 0; r < GPR_COUNT; r++) send_beat(op_rr(OP_LDI_L, r, 0), $urandom);

    drain();
    write_start_pc(32'hffff_fffe);
    send_beat(op_rr(OP_LDI_L, 2, 0), 32'h8000_0000);
    send_beat(op_rr(OP_LDI_B, 3, 0), 32'hffff_ffff);
    send_beat(op_rr(OP_LDI_S, 6, 0), 32'd0);
    send_beat(op_rr(OP_MOV, 4, 2), 0);
    send_beat(op_rr(OP_DIV, 4, 3), 0);
    send_beat(op_rr(OP_MOD, 2, 3), 0);
    send_beat(op_rr(OP_DIV, 3, 6), 0);
    send_beat(op_rr(OP_UMOD, 4, 6), 0);
    send_beat(op_rr(OP_LDI_L, 7, 0), 32'd32);
    send_beat(op_rr(OP_ASHR, 4, 7), 0);
    send_beat(op_rr(OP_LSHR, 3, 7), 0);
    send_beat(op_rr(OP_CMP, 4, 6), 0);
    send_beat({2'b11, BR_LT, 10'h200}, 0);
    send_beat({2'b11, 4'hf, 10'h1ff}, 0);
    send_beat(op_rr(OP_BRK, 0, 0), 0);
    send_beat(16'h0000, 0);
    send_beat({2'b10, F2_SSR, 4'd4, 8'hff}, 0);
    send_beat({2'b10, F2_GSR, 4'd9, 8'hff}, 0);
    send_beat({2'b10, F2_INC, 4'd9, 8'hff}, 0);
    send_beat(op_rr(OP_SWI, 0, 0), SWI_EXIT);
    send_beat(op_rr(OP_SWI, 0, 0), SWI_CALL);
    send_beat(op_rr(OP_RET, 0, 0), 0);
    send_beat(op_rr(OP_PUSH, 1, 1), 0);
    send_beat(op_rr(OP_POP, 1, 1), 0);
    send_beat(op_rr(OP_JSRA, 0, 0), 32'h0000_0100);

    // store a word, read it back in every width and mode, jump on most reads to show the values
    send_beat(op_rr(OP_LDI_L, 5, 0), 32'h0000_0100);
    send_beat(op_rr(OP_LDI_L, 8, 0), 32'h1234_5678);
    send_beat(op_rr(OP_STA_L, 8, 0), 32'h0000_0100);
    send_beat(op_rr(OP_LDA_L, 9, 0), 32'h0000_0100);
    send_beat(op_rr(OP_JMP, 9, 0), 0);
    send_beat(op_rr(OP_LD_B, 10, 5), 0);
    send_beat(op_rr(OP_JMP, 10, 0), 0);
    send_beat(op_rr(OP_LDO_S, 11, 5), 32'd2);
    send_beat(op_rr(OP_JMP, 11, 0), 0);
    send_beat(op_rr(OP_LDA_S, 12, 0), 32'h0000_0101);
    send_beat(op_rr(OP_JMP, 12, 0), 0);
    send_beat(op_rr(OP_LD_L, 13, 5), 0);
    send_beat(op_rr(OP_LDO_B, 14, 5), 32'd3);
    send_beat(op_rr(OP_JMP, 14, 0), 0);
    send_beat(op_rr(OP_LDO_L, 15, 5), 32'd0);
    send_beat(op_rr(OP_LDA_B, 9, 0), 32'h0000_0103);
    send_beat(op_rr(OP_LD_S, 10, 5), 0);
    send_beat(op_rr(OP_JMP, 10, 0), 0);
    send_beat(op_rr(OP_STA_L, 8, 0), 32'hffff_fffe);
    send_beat(op_rr(OP_LDA_L, 9, 0), 32'hffff_fffe);
    send_beat(op_rr(OP_JMP, 9, 0), 0);

    drain();
    write_start_pc($urandom);
    send_random(600);
    drain();
    write_start_pc(32'hffff_ffff);
    send_random(600);
    drain();
    write_start_pc(32'h0000_1000);
    quiet = 1;
    send_random(500);
    drain();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
hdl/cie_pkg.sv
hdl/cie_ram.sv
hdl/cie_front.sv
hdl/cie_div.sv
hdl/cie_exec.sv
hdl/cpu_instruction_execute_top.sv
tb/sv/cpu_instruction_execute_checker.sv
tb/sv/tb_cpu_instruction_execute_top.sv
